[rtl/message_to_frame_segmenter_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the message to frame segmenter.
// Both macros assume signals named clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_TO_FRAME_SEGMENTER_UNIT_MACROS_SVH
`define MESSAGE_TO_FRAME_SEGMENTER_UNIT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define MTFS_ASSERT_SAME(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("segmenter assertion failed in the same cycle");

// The consequence must hold in the cycle after the condition.
`define MTFS_ASSERT_NEXT(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("segmenter assertion failed one cycle later");

`endif

[rtl/mtfs_pkg.sv]
// ----------------------------------------------------------------------------
// mtfs_pkg
// Types, constants and helper functions shared by the segmenter modules.
// ----------------------------------------------------------------------------
package mtfs_pkg;

  localparam logic [13:0] FRAME_MIN   = 14'd64;
  localparam logic [13:0] FRAME_MAX   = 14'd9000;
  localparam logic [13:0] FRAME_RESET = 14'd1460;
  localparam logic [13:0] HDR_BYTES   = 14'd8;
  localparam logic [7:0]  DATA_TYPE   = 8'd2;
  localparam logic [7:0]  KEEP_ALL    = 8'hff;

  localparam logic [3:0] KIND_ENV  = 4'd0;
  localparam logic [3:0] KIND_DATA = 4'd1;

  localparam int QDEPTH = 2;
  localparam int QPTRW  = $clog2(QDEPTH);

  localparam int NSLOTS      = 5;
  localparam int SLOT_PRE    = 0;
  localparam int SLOT_HDR_A  = 1;
  localparam int SLOT_BEAT   = 2;
  localparam int SLOT_HDR_B  = 3;
  localparam int SLOT_POST   = 4;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STREAM,
    MODE_REALIGN
  } mode_t;

  typedef struct packed {
    logic [NSLOTS-1:0] mask;
    logic [31:0]       pre_data;
    logic [3:0]        pre_keep;
    logic [7:0]        pre_dest;
    logic [7:0]        hdr_dest;
    logic [7:0]        hdr_id;
    logic [3:0]        hdr_tag;
    logic [15:0]       len_a;
    logic [15:0]       len_b;
    logic [63:0]       beat_data;
    logic [7:0]        beat_dest;
    logic [7:0]        beat_keep;
    logic              beat_last;
    logic [31:0]       post_data;
    logic [3:0]        post_keep;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic             full;
    logic [QPTRW:0]   count;
  } q_stat_t;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

  function automatic logic [63:0] hdr_word(input logic [7:0] dest, input logic [7:0] id,
                                           input logic [15:0] len, input logic [3:0] tag);
    return {4'h0, tag, 8'h00, len, DATA_TYPE, id, 8'h00, dest};
  endfunction

endpackage

[rtl/mtfs_front.sv]
// ----------------------------------------------------------------------------
// mtfs_front
// Accepts input words, tracks message state and turns each word into at most
// one command that lists the output words it causes.
// ----------------------------------------------------------------------------
module mtfs_front import mtfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data,
  input  logic [7:0]  in_dest,
  input  logic [7:0]  in_keep,
  input  logic        in_last,
  input  logic [7:0]  in_msg_id,
  input  logic [3:0]  in_src_tag,
  input  logic [3:0]  in_kind,
  input  logic [31:0] in_msg_size,
  input  logic        q_full,
  output logic        push,
  output cmd_t        cmd
);

  mode_t       mode_r, mode_nxt;
  logic [13:0] frame_len_r, frame_len_nxt;
  logic [13:0] fbc_r, fbc_nxt;
  logic [31:0] br_r, br_nxt;
  logic [7:0]  hdr_dest_r, hdr_dest_nxt;
  logic [7:0]  hdr_id_r, hdr_id_nxt;
  logic [3:0]  hdr_tag_r, hdr_tag_nxt;
  logic [31:0] carry_data_r, carry_data_nxt;
  logic [3:0]  carry_keep_r, carry_keep_nxt;
  logic [7:0]  prev_dest_r, prev_dest_nxt;

  logic        accept;
  logic        is_idle, is_stream, is_realign;
  logic        realign_full, realign_norm, do_stream, cut;
  logic        first_data, envelope;
  logic        h1_en, h2_en, beat_en, post_en;
  logic [13:0] lim_full, sfbc, rl_fbc;
  logic [7:0]  rl_keep;
  logic [31:0] br_base, lim1, lim2, d1, d2, br_after1, br_after2;
  logic        ge1, ge2;
  logic [15:0] len_first, len_second;
  logic [13:0] cfg_clamped;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    if (cfg_data < FRAME_MIN) begin
      cfg_clamped = FRAME_MIN;
    end else if (cfg_data > FRAME_MAX) begin
      cfg_clamped = FRAME_MAX;
    end else begin
      cfg_clamped = cfg_data;
    end
    frame_len_nxt = (cfg_valid && cfg_ready) ? (cfg_clamped - HDR_BYTES) : frame_len_r;
  end

  // Classification of the current word.
  always_comb begin
    is_idle      = (mode_r == MODE_IDLE);
    is_stream    = (mode_r == MODE_STREAM);
    is_realign   = (mode_r == MODE_REALIGN);
    lim_full     = frame_len_r - HDR_BYTES;
    realign_full = is_realign && (fbc_r >= lim_full);
    realign_norm = is_realign && !realign_full;
    do_stream    = is_stream || realign_full;
    first_data   = is_idle && (in_kind == KIND_DATA);
    envelope     = is_idle && (in_kind == KIND_ENV);
    sfbc         = (realign_full ? 14'd0 : fbc_r) + {10'd0, ones8(in_keep)};
    cut          = do_stream && (sfbc >= frame_len_r);
    rl_keep      = {in_keep[3:0], carry_keep_r};
    rl_fbc       = fbc_r + {10'd0, ones8(rl_keep)};
    h1_en        = first_data || realign_full;
    h2_en        = cut;
    beat_en      = envelope || first_data || do_stream || realign_norm;
    post_en      = in_last && (cut || realign_norm);
  end

  // Chunk lengths for up to two headers, both evaluated in parallel.
  always_comb begin
    br_base    = is_idle ? in_msg_size : br_r;
    lim1       = {18'd0, frame_len_r};
    lim2       = {17'd0, frame_len_r, 1'b0};
    ge1        = (br_base >= lim1);
    ge2        = (br_base >= lim2);
    d1         = br_base - lim1;
    d2         = br_base - lim2;
    len_first  = ge1 ? {2'b00, frame_len_r} : br_base[15:0];
    len_second = ge2 ? {2'b00, frame_len_r} : (ge1 ? d1[15:0] : br_base[15:0]);
    br_after1  = ge1 ? d1 : br_base;
    br_after2  = ge2 ? d2 : br_after1;
  end

  // Next state.
  always_comb begin
    mode_nxt       = mode_r;
    fbc_nxt        = fbc_r;
    br_nxt         = br_r;
    hdr_dest_nxt   = hdr_dest_r;
    hdr_id_nxt     = hdr_id_r;
    hdr_tag_nxt    = hdr_tag_r;
    carry_data_nxt = carry_data_r;
    carry_keep_nxt = carry_keep_r;
    prev_dest_nxt  = prev_dest_r;
    if (accept) begin
      if (h1_en && h2_en) begin
        br_nxt = br_after2;
      end else if (h1_en || h2_en) begin
        br_nxt = br_after1;
      end
      case (mode_r)
        MODE_IDLE: begin
          if (first_data) begin
            hdr_dest_nxt  = in_dest;
            hdr_id_nxt    = in_msg_id;
            hdr_tag_nxt   = in_src_tag;
            prev_dest_nxt = in_dest;
            fbc_nxt       = HDR_BYTES;
            mode_nxt      = in_last ? MODE_IDLE : MODE_STREAM;
          end
        end
        MODE_STREAM, MODE_REALIGN: begin
          prev_dest_nxt = in_dest;
          if (do_stream) begin
            if (cut) begin
              fbc_nxt        = 14'd0;
              carry_data_nxt = in_data[63:32];
              carry_keep_nxt = in_keep[7:4];
              mode_nxt       = in_last ? MODE_IDLE : MODE_REALIGN;
            end else begin
              fbc_nxt  = sfbc;
              mode_nxt = in_last ? MODE_IDLE : MODE_STREAM;
            end
          end else begin
            carry_data_nxt = in_data[63:32];
            carry_keep_nxt = in_keep[7:4];
            fbc_nxt        = in_last ? 14'd0 : rl_fbc;
            mode_nxt       = in_last ? MODE_IDLE : MODE_REALIGN;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
    end
  end

  // Command for the back end.
  always_comb begin
    cmd                 = '0;
    cmd.mask[SLOT_PRE]   = realign_full;
    cmd.mask[SLOT_HDR_A] = h1_en;
    cmd.mask[SLOT_BEAT]  = beat_en;
    cmd.mask[SLOT_HDR_B] = h2_en;
    cmd.mask[SLOT_POST]  = post_en;
    cmd.pre_data  = carry_data_r;
    cmd.pre_keep  = carry_keep_r;
    cmd.pre_dest  = prev_dest_r;
    cmd.hdr_dest  = first_data ? in_dest : hdr_dest_r;
    cmd.hdr_id    = first_data ? in_msg_id : hdr_id_r;
    cmd.hdr_tag   = first_data ? in_src_tag : hdr_tag_r;
    cmd.len_a     = len_first;
    cmd.len_b     = h1_en ? len_second : len_first;
    cmd.beat_dest = in_dest;
    cmd.post_data = in_data[63:32];
    cmd.post_keep = in_keep[7:4];
    if (envelope) begin
      cmd.beat_data = {4'h0, in_src_tag, in_data[55:0]};
      cmd.beat_keep = in_keep;
      cmd.beat_last = in_last;
    end else if (realign_norm) begin
      cmd.beat_data = {in_data[31:0], carry_data_r};
      cmd.beat_keep = rl_keep;
      cmd.beat_last = 1'b0;
    end else if (cut) begin
      cmd.beat_data = {32'd0, in_data[31:0]};
      cmd.beat_keep = {4'h0, in_keep[3:0]};
      cmd.beat_last = 1'b1;
    end else begin
      cmd.beat_data = in_data;
      cmd.beat_keep = in_keep;
      cmd.beat_last = in_last;
    end
    push = accept && (|cmd.mask);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      fbc_r       <= '0;
      frame_len_r <= FRAME_RESET - HDR_BYTES;
    end else begin
      mode_r      <= mode_nxt;
      fbc_r       <= fbc_nxt;
      frame_len_r <= frame_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    br_r         <= br_nxt;
    hdr_dest_r   <= hdr_dest_nxt;
    hdr_id_r     <= hdr_id_nxt;
    hdr_tag_r    <= hdr_tag_nxt;
    carry_data_r <= carry_data_nxt;
    carry_keep_r <= carry_keep_nxt;
    prev_dest_r  <= prev_dest_nxt;
  end

endmodule

[rtl/mtfs_cmd_queue.sv]
// ----------------------------------------------------------------------------
// mtfs_cmd_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mtfs_cmd_queue import mtfs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t             entries_r [QDEPTH];
  logic [QPTRW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTRW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTRW:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    stat.count = count_r;
    stat.valid = (count_r != '0);
    stat.full  = (count_r == QDEPTH[QPTRW:0]);
    do_push    = push && !stat.full;
    do_pop     = pop && stat.valid;
    head       = entries_r[rd_ptr_r];
    wr_ptr_nxt = do_push ? (wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? (rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + {{QPTRW{1'b0}}, do_push} - {{QPTRW{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/mtfs_back.sv]
// ----------------------------------------------------------------------------
// mtfs_back
// Expands queued commands into output words through a registered output
// stage, one word per cycle while out_ready does not stall it.
// ----------------------------------------------------------------------------
module mtfs_back import mtfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        head,
  output logic        pop,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data,
  output logic [7:0]  out_dest,
  output logic [7:0]  out_keep,
  output logic        out_last
);

  cmd_t              cmd_r, cmd_nxt;
  logic [NSLOTS-1:0] mask_r, mask_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_data_r, out_data_nxt;
  logic [7:0]        out_dest_r, out_dest_nxt;
  logic [7:0]        out_keep_r, out_keep_nxt;
  logic              out_last_r, out_last_nxt;

  logic              load, from_q;
  logic [NSLOTS-1:0] src_mask, sel;
  cmd_t              src;

  always_comb begin
    load     = !out_valid_r || out_ready;
    from_q   = (mask_r == '0);
    src      = from_q ? head : cmd_r;
    src_mask = from_q ? (q_valid ? head.mask : '0) : mask_r;
    sel      = src_mask & (~src_mask + {{(NSLOTS-1){1'b0}}, 1'b1});
    pop      = load && from_q && q_valid;
    busy     = !from_q;
  end

  always_comb begin
    cmd_nxt       = pop ? head : cmd_r;
    mask_nxt      = load ? (src_mask & ~sel) : mask_r;
    out_valid_nxt = load ? (|src_mask) : out_valid_r;
    out_data_nxt  = out_data_r;
    out_dest_nxt  = out_dest_r;
    out_keep_nxt  = out_keep_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      if (sel[SLOT_PRE]) begin
        out_data_nxt = {32'd0, src.pre_data};
        out_dest_nxt = src.pre_dest;
        out_keep_nxt = {4'h0, src.pre_keep};
        out_last_nxt = 1'b1;
      end else if (sel[SLOT_HDR_A]) begin
        out_data_nxt = hdr_word(src.hdr_dest, src.hdr_id, src.len_a, src.hdr_tag);
        out_dest_nxt = src.hdr_dest;
        out_keep_nxt = KEEP_ALL;
        out_last_nxt = 1'b0;
      end else if (sel[SLOT_BEAT]) begin
        out_data_nxt = src.beat_data;
        out_dest_nxt = src.beat_dest;
        out_keep_nxt = src.beat_keep;
        out_last_nxt = src.beat_last;
      end else if (sel[SLOT_HDR_B]) begin
        out_data_nxt = hdr_word(src.hdr_dest, src.hdr_id, src.len_b, src.hdr_tag);
        out_dest_nxt = src.hdr_dest;
        out_keep_nxt = KEEP_ALL;
        out_last_nxt = 1'b0;
      end else if (sel[SLOT_POST]) begin
        out_data_nxt = {32'd0, src.post_data};
        out_dest_nxt = src.beat_dest;
        out_keep_nxt = {4'h0, src.post_keep};
        out_last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
    out_dest_r <= out_dest_nxt;
    out_keep_r <= out_keep_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_dest  = out_dest_r;
  assign out_keep  = out_keep_r;
  assign out_last  = out_last_r;

endmodule

[rtl/message_to_frame_segmenter_unit.sv]
// ----------------------------------------------------------------------------
// message_to_frame_segmenter_unit
// Turns a 64-bit application stream into network frames. The front end takes
// one input word per cycle and turns it into a command of one to five output
// words; a two-entry command queue feeds the back end, which sends one output
// word per cycle while out_ready is high, through a registered output stage.
// A word that yields a single output word therefore flows at one per cycle,
// and a word that yields more output words holds the back end until they are
// all sent, so the input stalls once the queue fills. The first output word
// of an input word passes through the queue entry and the output register.
// The user must write the frame size register through the cfg port only while
// the block has no work in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "message_to_frame_segmenter_unit_macros.svh"

module message_to_frame_segmenter_unit import mtfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data,
  input  logic [7:0]  in_dest,
  input  logic [7:0]  in_keep,
  input  logic        in_last,
  input  logic [7:0]  in_msg_id,
  input  logic [3:0]  in_src_tag,
  input  logic [3:0]  in_kind,
  input  logic [31:0] in_msg_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data,
  output logic [7:0]  out_dest,
  output logic [7:0]  out_keep,
  output logic        out_last
);

  logic    fe_push;
  cmd_t    fe_cmd;
  cmd_t    q_head;
  q_stat_t q_stat;
  logic    bk_pop;
  logic    bk_busy;

  mtfs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .in_dest     (in_dest),
    .in_keep     (in_keep),
    .in_last     (in_last),
    .in_msg_id   (in_msg_id),
    .in_src_tag  (in_src_tag),
    .in_kind     (in_kind),
    .in_msg_size (in_msg_size),
    .q_full      (q_stat.full),
    .push        (fe_push),
    .cmd         (fe_cmd)
  );

  mtfs_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fe_push),
    .push_cmd (fe_cmd),
    .pop      (bk_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  mtfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_stat.valid),
    .head      (q_head),
    .pop       (bk_pop),
    .busy      (bk_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .out_dest  (out_dest),
    .out_keep  (out_keep),
    .out_last  (out_last)
  );

  `MTFS_ASSERT_NEXT(a_back_fills, !bk_busy && q_stat.valid && (out_ready || !out_valid), out_valid)
  `MTFS_ASSERT_SAME(a_push_nonempty, fe_push, fe_cmd.mask != '0)
  `MTFS_ASSERT_SAME(a_no_push_full, fe_push, !q_stat.full)

endmodule
